// File: rtl/imhq_pkg.sv
package imhq_pkg;

    localparam int Capacity = 1024;
    localparam int AddrW    = 10;
    localparam int PosW     = 11;
    localparam int KeyW     = 32;
    localparam int IdW      = 16;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_CHANGE = 2'd2;
    localparam logic [1:0] FUNC_PEEK   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_SAME    = 2'd3;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE     = 4'd0,
        CMD_LATCH    = 4'd1,   // capture request, read target slot
        CMD_START    = 4'd2,   // decide operation, set up traveling entry
        CMD_RD_LAST  = 4'd3,   // read last entry for delete refill
        CMD_GET_LAST = 4'd4,   // take last entry as traveling entry
        CMD_RD_PAR   = 4'd5,   // read parent of hole
        CMD_UP_TEST  = 4'd6,   // compare parent, move if smaller
        CMD_RD_KIDS  = 4'd7,   // read left child
        CMD_RD_KID2  = 4'd8,   // read right child
        CMD_DN_TEST  = 4'd9,   // compare children, move if smaller
        CMD_PLACE    = 4'd10,  // write traveling entry into hole
        CMD_DONE     = 4'd11   // emit completion
    } cmd_t;

    typedef struct packed {
        logic       op_end;     // operation needs only the completion
        logic       need_last;  // delete with refill
        logic       up_go;      // parent exists
        logic       up_moved;   // entry moved up
        logic       dn_has_l;   // left child exists
        logic       dn_has_r;   // right child exists
        logic       dn_moved;   // entry moved down
        logic       out_busy;   // output register holds a stalled result
    } stat_t;

endpackage

// File: rtl/indexed_min_heap_queue_top.sv
// Indexed binary min-heap queue of 16-bit ids keyed by 32-bit values.
// Input channel: in_valid/in_stall with func, item_id, item_key, position.
// Output channel: out_valid/out_stall with kind, out_id, out_key,
// out_position, status, count, last. A request is taken when valid is high
// and stall is low. One request is processed at a time, so the throughput
// is one request per request latency.
// Each request yields one update result per moved entry and one for the
// placed entry, then a completion (last = 1); a request that ends at once
// yields only the completion. The steps are accept and decode, the refill
// read of a delete, sift up, sift down, then place, complete and free the
// input, all paced by the single read port of the heap memory.
// in_stall is high from acceptance through the S_WAIT state that follows
// the completion entering the output register. A stalled output holds its
// result and the sequencer pauses until it drains.
// Reset clears the entry count and the control state; the heap memory is
// not cleared and only slots below the count are used.
module indexed_min_heap_queue_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   func,
    input  logic [imhq_pkg::IdW-1:0]     item_id,
    input  logic [imhq_pkg::KeyW-1:0]    item_key,
    input  logic [imhq_pkg::PosW-1:0]    position,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kind,
    output logic [imhq_pkg::IdW-1:0]     out_id,
    output logic [imhq_pkg::KeyW-1:0]    out_key,
    output logic [imhq_pkg::PosW-1:0]    out_position,
    output logic [1:0]                   status,
    output logic [imhq_pkg::PosW-1:0]    count,
    output logic                         last
);

    imhq_pkg::cmd_t  cmd;
    imhq_pkg::stat_t stat;

    // Sequencer.
    imhq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Heap memory, compare logic and output register.
    imhq_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .func         (func),
        .item_id      (item_id),
        .item_key     (item_key),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .out_id       (out_id),
        .out_key      (out_key),
        .out_position (out_position),
        .status       (status),
        .count        (count),
        .last         (last)
    );

endmodule

// File: rtl/imhq_ctrl.sv
module imhq_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output imhq_pkg::cmd_t   cmd,
    input  imhq_pkg::stat_t  stat
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_START   = 12'b000000000010,
        S_RDLAST  = 12'b000000000100,
        S_GETLAST = 12'b000000001000,
        S_RDPAR   = 12'b000000010000,
        S_UPTEST  = 12'b000000100000,
        S_RDL     = 12'b000001000000,
        S_RDR     = 12'b000010000000,
        S_DNTEST  = 12'b000100000000,
        S_PLACE   = 12'b001000000000,
        S_DONE    = 12'b010000000000,
        S_WAIT    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    // Sequencer for one request; states that emit a result wait for the output register.
    always_comb
    begin
        state_next = state_reg;
        cmd        = imhq_pkg::CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = imhq_pkg::CMD_LATCH;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd = imhq_pkg::CMD_START;
                if (stat.op_end)
                    state_next = S_DONE;
                else if (stat.need_last)
                    state_next = S_RDLAST;
                else
                    state_next = S_RDPAR;
            end
            S_RDLAST:
            begin
                cmd        = imhq_pkg::CMD_RD_LAST;
                state_next = S_GETLAST;
            end
            S_GETLAST:
            begin
                cmd        = imhq_pkg::CMD_GET_LAST;
                state_next = S_RDPAR;
            end
            S_RDPAR:
            begin
                cmd = imhq_pkg::CMD_RD_PAR;
                if (stat.up_go)
                    state_next = S_UPTEST;
                else
                    state_next = S_RDL;
            end
            S_UPTEST:
            begin
                if (!stat.out_busy)
                begin
                    cmd = imhq_pkg::CMD_UP_TEST;
                    if (stat.up_moved)
                        state_next = S_RDPAR;
                    else
                        state_next = S_RDL;
                end
            end
            S_RDL:
            begin
                cmd = imhq_pkg::CMD_RD_KIDS;
                if (stat.dn_has_l)
                    state_next = S_RDR;
                else
                    state_next = S_PLACE;
            end
            S_RDR:
            begin
                cmd        = imhq_pkg::CMD_RD_KID2;
                state_next = S_DNTEST;
            end
            S_DNTEST:
            begin
                if (!stat.out_busy)
                begin
                    cmd = imhq_pkg::CMD_DN_TEST;
                    if (stat.dn_moved)
                        state_next = S_RDL;
                    else
                        state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (!stat.out_busy)
                begin
                    cmd        = imhq_pkg::CMD_PLACE;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd        = imhq_pkg::CMD_DONE;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_START))
        else $error("accept did not start");
    a_done_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == imhq_pkg::CMD_DONE) |=> (state_reg == S_WAIT))
        else $error("completion sequencing");
`endif

endmodule

// File: rtl/imhq_dp.sv
module imhq_dp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  imhq_pkg::cmd_t               cmd,
    output imhq_pkg::stat_t              stat,
    input  logic [1:0]                   func,
    input  logic [imhq_pkg::IdW-1:0]     item_id,
    input  logic [imhq_pkg::KeyW-1:0]    item_key,
    input  logic [imhq_pkg::PosW-1:0]    position,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kind,
    output logic [imhq_pkg::IdW-1:0]     out_id,
    output logic [imhq_pkg::KeyW-1:0]    out_key,
    output logic [imhq_pkg::PosW-1:0]    out_position,
    output logic [1:0]                   status,
    output logic [imhq_pkg::PosW-1:0]    count,
    output logic                         last
);

    localparam int EW = imhq_pkg::IdW + imhq_pkg::KeyW;

    // Heap storage: one entry {id, key} per slot, one read and one write port.
    logic [EW-1:0] mem [imhq_pkg::Capacity];
    logic [EW-1:0] rd_data_reg;
    logic                         rd_en, wr_en;
    logic [imhq_pkg::AddrW-1:0]   rd_addr, wr_addr;
    logic [EW-1:0]                wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    logic [1:0]                   func_reg;
    logic [imhq_pkg::IdW-1:0]     id_reg, rid_reg;
    logic [imhq_pkg::KeyW-1:0]    key_reg, rkey_reg, lkey_reg;
    logic [imhq_pkg::IdW-1:0]     lid_reg;
    logic [imhq_pkg::PosW-1:0]    pos_reg, hole_reg, cnt_reg;
    logic [1:0]                   st_reg;

    logic                         ov_reg;
    logic                         okind_reg, olast_reg;
    logic [imhq_pkg::IdW-1:0]     oid_reg;
    logic [imhq_pkg::KeyW-1:0]    okey_reg;
    logic [imhq_pkg::PosW-1:0]    opos_reg, ocnt_reg;
    logic [1:0]                   ost_reg;

    logic [imhq_pkg::KeyW-1:0]    rkey;
    logic [imhq_pkg::IdW-1:0]     rid;
    logic [imhq_pkg::PosW-1:0]    parent, lchild, rchild;
    logic                         valid_pos, full;
    logic [imhq_pkg::PosW:0]      lchild_w;

    assign rkey      = rd_data_reg[imhq_pkg::KeyW-1:0];
    assign rid       = rd_data_reg[EW-1:imhq_pkg::KeyW];
    assign parent    = hole_reg >> 1;
    assign lchild_w  = {hole_reg, 1'b0};
    assign lchild    = lchild_w[imhq_pkg::PosW-1:0];
    assign rchild    = lchild + imhq_pkg::PosW'(1);
    assign valid_pos = (pos_reg != '0) && (pos_reg <= cnt_reg);
    assign full      = (cnt_reg >= imhq_pkg::PosW'(imhq_pkg::Capacity));

    // Status toward the controller.
    always_comb
    begin
        stat.op_end    = 1'b0;
        stat.need_last = 1'b0;
        case (func_reg)
            imhq_pkg::FUNC_INSERT: stat.op_end = full;
            imhq_pkg::FUNC_DELETE:
            begin
                stat.op_end    = !valid_pos || (pos_reg == cnt_reg);
                stat.need_last = 1'b1;
            end
            imhq_pkg::FUNC_CHANGE: stat.op_end = !valid_pos || (rkey == key_reg);
            default:               stat.op_end = 1'b1;
        endcase
        stat.up_go    = (hole_reg > imhq_pkg::PosW'(1));
        stat.up_moved = (key_reg < rkey);
        stat.dn_has_l = ({1'b0, lchild_w} <= {2'b0, cnt_reg});
        stat.dn_has_r = (rchild <= cnt_reg) && !lchild_w[imhq_pkg::PosW];
        stat.dn_moved = (stat.dn_has_r && ((rkey < key_reg) || (lkey_reg < key_reg)))
                        || (!stat.dn_has_r && (lkey_reg < key_reg));
        stat.out_busy = ov_reg && out_stall;
    end

    // The right child wins a tie between the two children.
    logic dn_has_r_reg;
    logic pick_r;
    assign pick_r = dn_has_r_reg && (rkey <= lkey_reg);

    // Memory address and write control.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = {id_reg, key_reg};
        case (cmd)
            imhq_pkg::CMD_LATCH:
            begin
                rd_en   = 1'b1;
                rd_addr = imhq_pkg::AddrW'(position - imhq_pkg::PosW'(1));
                if (func == imhq_pkg::FUNC_PEEK)
                    rd_addr = '0;
            end
            imhq_pkg::CMD_RD_LAST:
            begin
                rd_en   = 1'b1;
                rd_addr = imhq_pkg::AddrW'(cnt_reg);
            end
            imhq_pkg::CMD_RD_PAR:
            begin
                rd_en   = 1'b1;
                rd_addr = imhq_pkg::AddrW'(parent - imhq_pkg::PosW'(1));
            end
            imhq_pkg::CMD_UP_TEST:
            begin
                wr_en   = stat.up_moved;
                wr_addr = imhq_pkg::AddrW'(hole_reg - imhq_pkg::PosW'(1));
                wr_data = rd_data_reg;
            end
            imhq_pkg::CMD_RD_KIDS:
            begin
                rd_en   = 1'b1;
                rd_addr = imhq_pkg::AddrW'(lchild - imhq_pkg::PosW'(1));
            end
            imhq_pkg::CMD_RD_KID2:
            begin
                rd_en   = 1'b1;
                rd_addr = imhq_pkg::AddrW'(lchild);
            end
            imhq_pkg::CMD_DN_TEST:
            begin
                wr_en   = stat.dn_moved;
                wr_addr = imhq_pkg::AddrW'(hole_reg - imhq_pkg::PosW'(1));
                wr_data = pick_r ? rd_data_reg : {lid_reg, lkey_reg};
            end
            imhq_pkg::CMD_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = imhq_pkg::AddrW'(hole_reg - imhq_pkg::PosW'(1));
            end
            default:
            begin
            end
        endcase
    end

    // Request and traveling-entry registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            case (cmd)
                imhq_pkg::CMD_LATCH:
                begin
                    func_reg <= func;
                    id_reg   <= item_id;
                    key_reg  <= item_key;
                    pos_reg  <= position;
                    st_reg   <= imhq_pkg::ST_OK;
                end
                imhq_pkg::CMD_START:
                begin
                    rid_reg  <= rid;
                    rkey_reg <= rkey;
                    hole_reg <= pos_reg;
                    case (func_reg)
                        imhq_pkg::FUNC_INSERT:
                        begin
                            if (full)
                            begin
                                st_reg   <= imhq_pkg::ST_FULL;
                                rid_reg  <= '0;
                                rkey_reg <= '0;
                            end
                            else
                            begin
                                cnt_reg  <= cnt_reg + imhq_pkg::PosW'(1);
                                hole_reg <= cnt_reg + imhq_pkg::PosW'(1);
                                rid_reg  <= id_reg;
                                rkey_reg <= key_reg;
                            end
                        end
                        imhq_pkg::FUNC_DELETE:
                        begin
                            if (!valid_pos)
                            begin
                                st_reg   <= imhq_pkg::ST_INVALID;
                                rid_reg  <= '0;
                                rkey_reg <= '0;
                            end
                            else
                                cnt_reg <= cnt_reg - imhq_pkg::PosW'(1);
                        end
                        imhq_pkg::FUNC_CHANGE:
                        begin
                            rkey_reg <= key_reg;
                            if (!valid_pos)
                            begin
                                st_reg   <= imhq_pkg::ST_INVALID;
                                rid_reg  <= '0;
                                rkey_reg <= '0;
                            end
                            else
                            begin
                                id_reg <= rid;
                                if (rkey == key_reg)
                                    st_reg <= imhq_pkg::ST_SAME;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_reg   <= imhq_pkg::ST_INVALID;
                                rid_reg  <= '0;
                                rkey_reg <= '0;
                            end
                        end
                    endcase
                end
                imhq_pkg::CMD_GET_LAST:
                begin
                    id_reg  <= rid;
                    key_reg <= rkey;
                end
                imhq_pkg::CMD_UP_TEST:
                begin
                    if (stat.up_moved)
                        hole_reg <= parent;
                end
                imhq_pkg::CMD_RD_KID2:
                begin
                    lid_reg      <= rid;
                    lkey_reg     <= rkey;
                    dn_has_r_reg <= stat.dn_has_r;
                end
                imhq_pkg::CMD_DN_TEST:
                begin
                    if (stat.dn_moved)
                        hole_reg <= pick_r ? rchild : lchild;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register: updates for moved and placed entries, then the completion.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
        begin
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if ((cmd == imhq_pkg::CMD_UP_TEST && stat.up_moved)
                || (cmd == imhq_pkg::CMD_DN_TEST && stat.dn_moved)
                || cmd == imhq_pkg::CMD_PLACE || cmd == imhq_pkg::CMD_DONE)
                ov_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            imhq_pkg::CMD_UP_TEST:
            begin
                okind_reg <= 1'b0;
                olast_reg <= 1'b0;
                oid_reg   <= rid;
                okey_reg  <= rkey;
                opos_reg  <= hole_reg;
                ost_reg   <= imhq_pkg::ST_OK;
                ocnt_reg  <= cnt_reg;
            end
            imhq_pkg::CMD_DN_TEST:
            begin
                okind_reg <= 1'b0;
                olast_reg <= 1'b0;
                oid_reg   <= pick_r ? rid : lid_reg;
                okey_reg  <= pick_r ? rkey : lkey_reg;
                opos_reg  <= hole_reg;
                ost_reg   <= imhq_pkg::ST_OK;
                ocnt_reg  <= cnt_reg;
            end
            imhq_pkg::CMD_PLACE:
            begin
                okind_reg <= 1'b0;
                olast_reg <= 1'b0;
                oid_reg   <= id_reg;
                okey_reg  <= key_reg;
                opos_reg  <= hole_reg;
                ost_reg   <= imhq_pkg::ST_OK;
                ocnt_reg  <= cnt_reg;
            end
            imhq_pkg::CMD_DONE:
            begin
                okind_reg <= 1'b1;
                olast_reg <= 1'b1;
                oid_reg   <= rid_reg;
                okey_reg  <= rkey_reg;
                opos_reg  <= '0;
                ost_reg   <= st_reg;
                ocnt_reg  <= cnt_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = ov_reg;
    assign kind         = okind_reg;
    assign out_id       = oid_reg;
    assign out_key      = okey_reg;
    assign out_position = opos_reg;
    assign status       = ost_reg;
    assign count        = ocnt_reg;
    assign last         = olast_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |-> (cmd != imhq_pkg::CMD_PLACE && cmd != imhq_pkg::CMD_DONE))
        else $error("output overwritten");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= imhq_pkg::PosW'(imhq_pkg::Capacity))
        else $error("count out of range");
    a_hole_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == imhq_pkg::CMD_PLACE) |-> (hole_reg != '0))
        else $error("place at slot zero");
`endif

endmodule
